// ===== sv/mbd_pkg.sv =====
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types, codes and the per-button tick update of the debounce core.
// ----------------------------------------------------------------------------
`default_nettype none

package mbd_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int BTN_W       = 3;
    localparam int CNT_W       = 16;
    localparam int FUNC_W      = 2;
    localparam int PINS_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 1;

    localparam logic [BTN_W-1:0] LAST_IDX = BTN_W'(NUM_BUTTONS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_PERIOD = 2'd2;

    localparam logic [PINS_W-1:0] ENABLE_MASK_RST    = 8'd0;
    localparam logic [CNT_W-1:0]  PRESS_PERIOD_RST   = 16'd20;
    localparam logic [CNT_W-1:0]  RELEASE_PERIOD_RST = 16'd100;

    localparam logic KIND_PRESS   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_PRESS   = 2'd1,
        FUNC_RELEASE = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        MODE_DISABLED   = 3'd0,
        MODE_UP         = 3'd1,
        MODE_PRESS_DB   = 3'd2,
        MODE_DOWN       = 3'd3,
        MODE_RELEASE_DB = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EDGE,
        ST_SWEEP,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        mode_t            mode;
        logic [CNT_W-1:0] count;
    } entry_t;

    localparam entry_t ENTRY_RST = '{mode: MODE_DISABLED, count: '0};

    typedef struct packed {
        logic             rd_en;
        logic [BTN_W-1:0] rd_addr;
        logic             wr_en;
        logic [BTN_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef struct packed {
        entry_t entry;
        logic   evt;
        logic   kind;
    } tick_res_t;

    function automatic tick_res_t tick_update(entry_t cur, logic enabled, logic pressed);
        tick_res_t r;
        logic      expired;
        r       = '{entry: cur, evt: 1'b0, kind: KIND_PRESS};
        expired = (cur.count <= CNT_W'(1));
        if (!enabled) begin
            r.entry = ENTRY_RST;
        end else begin
            case (cur.mode)
                MODE_DISABLED: begin
                    r.entry.mode = pressed ? MODE_DOWN : MODE_UP;
                end
                MODE_PRESS_DB: begin
                    r.entry.count = expired ? '0 : cur.count - CNT_W'(1);
                    if (expired) begin
                        if (pressed) begin
                            r.entry.mode = MODE_DOWN;
                            r.evt        = 1'b1;
                            r.kind       = KIND_PRESS;
                        end else begin
                            r.entry.mode = MODE_UP;
                        end
                    end
                end
                MODE_RELEASE_DB: begin
                    r.entry.count = expired ? '0 : cur.count - CNT_W'(1);
                    if (expired) begin
                        if (!pressed) begin
                            r.entry.mode = MODE_UP;
                            r.evt        = 1'b1;
                            r.kind       = KIND_RELEASE;
                        end else begin
                            r.entry.mode = MODE_DOWN;
                        end
                    end
                end
                MODE_UP, MODE_DOWN: begin
                    r.entry = cur;
                end
                default: begin
                    r.entry = ENTRY_RST;
                end
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mbd_state_mem.sv =====
// ----------------------------------------------------------------------------
// mbd_state_mem
// Per-button state store: one write and one registered read per cycle.
// Entries never written since reset read back as disabled with zero count.
// ----------------------------------------------------------------------------
`default_nettype none

module mbd_state_mem (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire mbd_pkg::mem_req_t req,
    output mbd_pkg::entry_t        rd_data
);
    import mbd_pkg::*;

    entry_t                 mem_q [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] valid_reg;
    entry_t                 rdata_reg;
    logic                   rvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_q[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rdata_reg <= mem_q[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rvalid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : ENTRY_RST;

endmodule

`default_nettype wire

// ===== sv/multi_button_debounce_fsm_core.sv =====
// ----------------------------------------------------------------------------
// multi_button_debounce_fsm_core
// Debounce machine for eight buttons, state held in a small synchronous RAM.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tuser: func; tdata: button, pin_levels
//  m_       out  m_tvalid/m_tready  tuser: kind; tdata: btn_index; tlast: last
//  cfg_     in   cfg_wr_en          cfg_index, cfg_wdata
//
//  Tick beat: accept, one entry per button, flush; one RAM read-modify-write
//  per cycle unless stalled. Edge: read, write if due. Unused: dropped.
//  A full output register with a second event pending stalls the sweep.
//  Reset: synchronous; entries read as disabled until first written.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_button_debounce_fsm_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mbd_pkg::S_TDATA_W-1:0]      s_tdata,   // button, pin_levels
    input  wire logic [mbd_pkg::S_TUSER_W-1:0]      s_tuser,   // func
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [mbd_pkg::M_TDATA_W-1:0]           m_tdata,   // btn_index
    output logic [mbd_pkg::M_TUSER_W-1:0]           m_tuser,   // kind
    output logic                                    m_tlast,
    input  wire logic                               cfg_wr_en,
    input  wire logic [mbd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mbd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import mbd_pkg::*;

    state_t              state_reg, state_next;
    func_t               func_reg, func_next;
    logic [BTN_W-1:0]    btn_reg, btn_next;
    logic [PINS_W-1:0]   pins_reg, pins_next;
    logic [BTN_W-1:0]    idx_reg, idx_next;

    logic                pend_valid_reg, pend_valid_next;
    logic [BTN_W-1:0]    pend_btn_reg, pend_btn_next;
    logic                pend_kind_reg, pend_kind_next;

    logic                m_valid_reg, m_valid_next;
    logic [BTN_W-1:0]    m_btn_reg, m_btn_next;
    logic                m_kind_reg, m_kind_next;
    logic                m_last_reg, m_last_next;

    logic [PINS_W-1:0]   enable_mask_reg;
    logic [CNT_W-1:0]    press_period_reg;
    logic [CNT_W-1:0]    release_period_reg;

    mem_req_t            mem_req;
    entry_t              rd_data;
    tick_res_t           tick_res;
    func_t               in_func;
    logic [BTN_W-1:0]    in_btn;
    logic [PINS_W-1:0]   in_pins;
    logic                out_free;
    logic                stall;

    mbd_state_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign in_func  = func_t'(s_tuser);
    assign in_btn   = s_tdata[BTN_W-1:0];
    assign in_pins  = s_tdata[BTN_W+PINS_W-1:BTN_W];
    assign out_free = !m_valid_reg || m_tready;
    assign tick_res = tick_update(rd_data, enable_mask_reg[idx_reg], pins_reg[idx_reg]);
    assign stall    = tick_res.evt && pend_valid_reg && !out_free;

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        btn_next        = btn_reg;
        pins_next       = pins_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_btn_next   = pend_btn_reg;
        pend_kind_next  = pend_kind_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_btn_next      = m_btn_reg;
        m_kind_next     = m_kind_reg;
        m_last_next     = m_last_reg;
        mem_req         = '{rd_en: 1'b0, rd_addr: '0, wr_en: 1'b0, wr_addr: '0,
                            wr_data: rd_data};
        s_tready        = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next = in_func;
                    btn_next  = in_btn;
                    pins_next = in_pins;
                    case (in_func)
                        FUNC_TICK: begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = '0;
                            idx_next        = '0;
                            state_next      = ST_SWEEP;
                        end
                        FUNC_PRESS, FUNC_RELEASE: begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = in_btn;
                            state_next      = ST_EDGE;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EDGE: begin
                state_next      = ST_IDLE;
                mem_req.wr_addr = btn_reg;
                if (enable_mask_reg[btn_reg]) begin
                    if (func_reg == FUNC_PRESS && rd_data.mode == MODE_UP) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_data = '{mode: MODE_PRESS_DB, count: press_period_reg};
                    end else if (func_reg == FUNC_RELEASE && rd_data.mode == MODE_DOWN) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_data = '{mode: MODE_RELEASE_DB,
                                            count: release_period_reg};
                    end
                end
            end
            ST_SWEEP: begin
                if (!stall) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = idx_reg;
                    mem_req.wr_data = tick_res.entry;
                    if (tick_res.evt) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_btn_next   = pend_btn_reg;
                            m_kind_next  = pend_kind_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_btn_next   = idx_reg;
                        pend_kind_next  = tick_res.kind;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_FLUSH;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_reg + BTN_W'(1);
                        idx_next        = idx_reg + BTN_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_btn_next      = pend_btn_reg;
                    m_kind_next     = pend_kind_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            pend_valid_reg     <= 1'b0;
            m_valid_reg        <= 1'b0;
            enable_mask_reg    <= ENABLE_MASK_RST;
            press_period_reg   <= PRESS_PERIOD_RST;
            release_period_reg <= RELEASE_PERIOD_RST;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ENABLE_MASK:    enable_mask_reg    <= cfg_wdata[PINS_W-1:0];
                    CFG_PRESS_PERIOD:   press_period_reg   <= cfg_wdata[CNT_W-1:0];
                    CFG_RELEASE_PERIOD: release_period_reg <= cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        btn_reg       <= btn_next;
        pins_reg      <= pins_next;
        idx_reg       <= idx_next;
        pend_btn_reg  <= pend_btn_next;
        pend_kind_reg <= pend_kind_next;
        m_btn_reg     <= m_btn_next;
        m_kind_reg    <= m_kind_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - BTN_W)'(0), m_btn_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // held event only exists while a tick is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE || state_reg == ST_EDGE) |-> !pend_valid_reg)
        else $error("pending event outside tick sweep");

    // RAM is only written while an item is being processed
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> (state_reg == ST_EDGE || state_reg == ST_SWEEP))
        else $error("state RAM written while idle");

    // the sweep finishes after the last entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && idx_reg == LAST_IDX && !stall) |=> state_reg == ST_FLUSH)
        else $error("sweep did not finish after last entry");

    // a stall keeps the sweep position and holds the read data
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && stall) |=> (state_reg == ST_SWEEP && $stable(idx_reg)))
        else $error("sweep moved during output stall");

    // the last held event of a tick is loaded into the output register with last set
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && pend_valid_reg && out_free) |=> (m_valid_reg && m_last_reg))
        else $error("final event not presented with last");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for multi_button_debounce_fsm_core. Tick and edge beats
// go into the stream input, and a behavioral model of the eight-button
// debounce table predicts the confirmed press and release events. Each output
// beat is checked against the oldest predicted event. Directed tests cover
// the defaults, mode changes, glitches, debounce timing and period extremes.
// A long receiver hold-off follows, then randomized traffic under several mask
// and period settings, mostly with random gaps on both sides.
// ----------------------------------------------------------------------------

module tb;

    import mbd_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        logic [BTN_W-1:0] btn;
        logic             kind;
        logic             last;
    } btn_event_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // model of the button table and its registers
    mode_t            btn_mode [NUM_BUTTONS];
    logic [CNT_W-1:0] btn_left [NUM_BUTTONS];
    logic [7:0]       en_mask;
    logic [CNT_W-1:0] press_ticks;
    logic [CNT_W-1:0] release_ticks;

    btn_event_t events_due[$];
    logic [7:0] pin_state;

    int  err_count;
    int  n_ticks;
    int  n_edges;
    int  n_unused;
    int  n_events;
    bit  tx_gaps;
    bit  rx_gaps;
    int  hold_req;
    int  hold_left;

    multi_button_debounce_fsm_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // button, pin_levels
        .s_tuser   (s_tuser),    // func
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // btn_index
        .m_tuser   (m_tuser),    // kind
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // --------------------------------------------------------------------
    // model
    // --------------------------------------------------------------------
    task automatic update_buttons(input logic [1:0] f, input logic [BTN_W-1:0] b,
                                  input logic [7:0] pins);
        btn_event_t fresh[$];
        logic       expired;
        if (f == FUNC_PRESS || f == FUNC_RELEASE) begin
            if (en_mask[b]) begin
                if (f == FUNC_PRESS && btn_mode[b] == MODE_UP) begin
                    btn_mode[b] = MODE_PRESS_DB;
                    btn_left[b] = press_ticks;
                end else if (f == FUNC_RELEASE && btn_mode[b] == MODE_DOWN) begin
                    btn_mode[b] = MODE_RELEASE_DB;
                    btn_left[b] = release_ticks;
                end
            end
        end else if (f == FUNC_TICK) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                if (!en_mask[i]) begin
                    btn_mode[i] = MODE_DISABLED;
                    btn_left[i] = '0;
                end else begin
                    expired = (btn_left[i] <= 1);
                    case (btn_mode[i])
                        MODE_DISABLED: begin
                            btn_mode[i] = pins[i] ? MODE_DOWN : MODE_UP;
                        end
                        MODE_PRESS_DB: begin
                            btn_left[i] = expired ? '0 : btn_left[i] - 1'b1;
                            if (expired && pins[i]) begin
                                btn_mode[i] = MODE_DOWN;
                                fresh.push_back('{btn: BTN_W'(i), kind: KIND_PRESS,
                                                  last: 1'b0});
                            end else if (expired) begin
                                btn_mode[i] = MODE_UP;
                            end
                        end
                        MODE_RELEASE_DB: begin
                            btn_left[i] = expired ? '0 : btn_left[i] - 1'b1;
                            if (expired && !pins[i]) begin
                                btn_mode[i] = MODE_UP;
                                fresh.push_back('{btn: BTN_W'(i), kind: KIND_RELEASE,
                                                  last: 1'b0});
                            end else if (expired) begin
                                btn_mode[i] = MODE_DOWN;
                            end
                        end
                        MODE_UP, MODE_DOWN: begin
                        end
                        default: begin
                            btn_mode[i] = MODE_DISABLED;
                            btn_left[i] = '0;
                        end
                    endcase
                end
            end
            if (fresh.size() > 0) begin
                fresh[fresh.size()-1].last = 1'b1;
            end
            foreach (fresh[k]) begin
                events_due.push_back(fresh[k]);
            end
        end
    endtask

    // --------------------------------------------------------------------
    // driving
    // --------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] f, input logic [BTN_W-1:0] b,
                             input logic [7:0] pins);
        @(negedge aclk);
        if (tx_gaps && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4)) @(negedge aclk);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {5'b0, pins, b};
        do @(posedge aclk); while (!s_tready);
        update_buttons(f, b, pins);
        if (f == FUNC_TICK) n_ticks++;
        else if (f == FUNC_UNUSED) n_unused++;
        else n_edges++;
    endtask

    // stop offering, wait for every event, then let any silent sweep finish
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (events_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_ENABLE_MASK:    en_mask       = val[7:0];
            CFG_PRESS_PERIOD:   press_ticks   = val;
            CFG_RELEASE_PERIOD: release_ticks = val;
            default: begin
            end
        endcase
    endtask

    task automatic set_config(input logic [7:0] mask, input logic [15:0] pp,
                              input logic [15:0] rp);
        wait_idle();
        cfg_write(CFG_ENABLE_MASK, {8'b0, mask});
        cfg_write(CFG_PRESS_PERIOD, pp);
        cfg_write(CFG_RELEASE_PERIOD, rp);
    endtask

    function automatic logic [BTN_W-1:0] pick_button(input mode_t want);
        logic [BTN_W-1:0] hits[$];
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (btn_mode[i] == want) hits.push_back(BTN_W'(i));
        end
        if (hits.size() == 0 || $urandom_range(4) == 0) begin
            return BTN_W'($urandom_range(NUM_BUTTONS - 1));
        end
        return hits[$urandom_range(hits.size() - 1)];
    endfunction

    // ticks and edges that mostly match the pin picture, with glitches and noise mixed in
    task automatic random_beat();
        int               r;
        logic [BTN_W-1:0] b;
        logic [7:0]       pins;
        r = $urandom_range(99);
        if (r < 45) begin
            pins = pin_state;
            if ($urandom_range(7) == 0) pins ^= 8'(1 << $urandom_range(7));
            send_beat(FUNC_TICK, BTN_W'($urandom_range(7)), pins);
        end else if (r < 70) begin
            b = pick_button(MODE_UP);
            pin_state[b] = ($urandom_range(9) != 0);
            send_beat(FUNC_PRESS, b, pin_state);
        end else if (r < 94) begin
            b = pick_button(MODE_DOWN);
            pin_state[b] = ($urandom_range(9) == 0);
            send_beat(FUNC_RELEASE, b, pin_state);
        end else begin
            send_beat(2'($urandom_range(3)), BTN_W'($urandom_range(7)),
                      8'($urandom_range(255)));
        end
    endtask

    // --------------------------------------------------------------------
    // receiver and checker
    // --------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (rx_gaps) begin
                m_tready <= ($urandom_range(99) >= 27);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_events
        btn_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (events_due.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected beat: button %0d kind %0b last %0b",
                             m_tdata[BTN_W-1:0], m_tuser[0], m_tlast);
            end else begin
                want = events_due.pop_front();
                n_events++;
                if (m_tdata[BTN_W-1:0] !== want.btn || m_tuser[0] !== want.kind
                        || m_tlast !== want.last) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: got button %0d kind %0b last %0b, %s %0d %0b %0b",
                                 m_tdata[BTN_W-1:0], m_tuser[0], m_tlast,
                                 "expected", want.btn, want.kind, want.last);
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // tests
    // --------------------------------------------------------------------
    task automatic test_after_reset();
        send_beat(FUNC_TICK, 3'd0, 8'hFF);
        send_beat(FUNC_PRESS, 3'd3, 8'h08);
        send_beat(FUNC_UNUSED, 3'd7, 8'hFF);
    endtask

    task automatic test_modes_and_glitches();
        set_config(8'hFF, 16'd1, 16'd1);
        send_beat(FUNC_TICK, 3'd0, 8'h0F);
        send_beat(FUNC_PRESS, 3'd7, 8'h8F);
        send_beat(FUNC_PRESS, 3'd0, 8'h8F);
        send_beat(FUNC_RELEASE, 3'd0, 8'h8E);
        send_beat(FUNC_RELEASE, 3'd6, 8'h8E);
        send_beat(FUNC_UNUSED, 3'd5, 8'h20);
        send_beat(FUNC_TICK, 3'd1, 8'h8E);
        send_beat(FUNC_PRESS, 3'd6, 8'h8E);
        send_beat(FUNC_TICK, 3'd2, 8'h8E);
        send_beat(FUNC_RELEASE, 3'd3, 8'h86);
        send_beat(FUNC_TICK, 3'd4, 8'h8E);
    endtask

    task automatic test_debounce_timing();
        set_config(8'hFF, 16'd3, 16'd2);
        send_beat(FUNC_PRESS, 3'd5, 8'hAE);
        send_beat(FUNC_TICK, 3'd0, 8'hAE);
        send_beat(FUNC_PRESS, 3'd5, 8'hAE);
        send_beat(FUNC_TICK, 3'd0, 8'hAE);
        send_beat(FUNC_TICK, 3'd0, 8'hAE);
    endtask

    task automatic test_period_extremes();
        set_config(8'hFF, 16'hFFFF, 16'hFFFF);
        send_beat(FUNC_PRESS, 3'd4, 8'hBE);
        send_beat(FUNC_RELEASE, 3'd7, 8'h3E);
        send_beat(FUNC_TICK, 3'd0, 8'h3E);
        set_config(8'h00, 16'hFFFF, 16'hFFFF);
        send_beat(FUNC_TICK, 3'd0, 8'h00);
        set_config(8'hFF, 16'd0, 16'd0);
        send_beat(FUNC_TICK, 3'd0, 8'h00);
        send_beat(FUNC_PRESS, 3'd2, 8'h04);
        send_beat(FUNC_TICK, 3'd0, 8'h04);
    endtask

    // receiver parked while every button confirms at once, twice
    task automatic test_backpressure();
        set_config(8'hFF, 16'd1, 16'd1);
        send_beat(FUNC_RELEASE, 3'd2, 8'h00);
        send_beat(FUNC_TICK, 3'd0, 8'h00);
        hold_req = 300;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            send_beat(FUNC_PRESS, BTN_W'(i), 8'(8'hFF >> (7 - i)));
        end
        send_beat(FUNC_TICK, 3'd0, 8'hFF);
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            send_beat(FUNC_RELEASE, BTN_W'(i), 8'(8'hFE << i));
        end
        send_beat(FUNC_TICK, 3'd0, 8'h00);
        send_beat(FUNC_TICK, 3'd0, 8'h00);
        pin_state = 8'h00;
    endtask

    task automatic test_random_traffic(input int count, input logic [7:0] mask,
                                       input logic [15:0] pp, input logic [15:0] rp,
                                       input bit gaps);
        set_config(mask, pp, rp);
        tx_gaps = gaps;
        rx_gaps = gaps;
        repeat (count) random_beat();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        en_mask       = ENABLE_MASK_RST;
        press_ticks   = PRESS_PERIOD_RST;
        release_ticks = RELEASE_PERIOD_RST;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            btn_mode[i] = MODE_DISABLED;
            btn_left[i] = '0;
        end
        pin_state = '0;
        err_count = 0;
        n_ticks   = 0;
        n_edges   = 0;
        n_unused  = 0;
        n_events  = 0;
        tx_gaps   = 1'b1;
        rx_gaps   = 1'b1;
        hold_req  = 0;
        hold_left = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_modes_and_glitches();
        test_debounce_timing();
        test_period_extremes();
        test_backpressure();
        test_random_traffic(90, 8'hFF, 16'd1, 16'd1, 1'b1);
        test_random_traffic(70, 8'hA5, 16'd3, 16'd2, 1'b1);
        test_random_traffic(70, 8'($urandom_range(255)), 16'($urandom_range(1, 4)),
                            16'($urandom_range(1, 6)), 1'b0);
        test_random_traffic(90, 8'hFF, 16'd2, 16'd5, 1'b1);
        wait_idle();

        $display("summary: %0d beats in (%0d ticks, %0d edges, %0d unused codes), %0d events",
                 n_ticks + n_edges + n_unused, n_ticks, n_edges, n_unused, n_events);
        $display("summary: masks 00/a5/ff/random, periods 0 to ffff, receiver hold-off");
        if (err_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

endmodule
